// ===== hdl/pee_pkg.sv =====
package pee_pkg;

	// Stack geometry
	localparam int STACK_DEPTH = 32;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W       = $clog2(STACK_DEPTH);

	// Field widths
	localparam int OPC_W  = 3;
	localparam int VAL_W  = 64;
	localparam int HALF_W = VAL_W / 2;
	localparam int NUM_W  = 32;
	localparam int TGT_W  = 32;
	localparam int DIST_W = 63;
	localparam int OPR_W  = 2;
	localparam int ERR_W  = 2;

	// Register port
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [IDX_W-1:0] idx_t;

	// Token kinds on the opcode field
	typedef enum logic [OPC_W-1:0] {
		TOK_NUM   = 3'd0,
		TOK_PLUS  = 3'd1,
		TOK_MINUS = 3'd2,
		TOK_TIMES = 3'd3,
		TOK_OPEN  = 3'd4,
		TOK_CLOSE = 3'd5,
		TOK_SKIP  = 3'd6
	} tok_t;

	// Operator stack entries
	typedef enum logic [OPR_W-1:0] {
		OP_PLUS  = 2'd0,
		OP_MINUS = 2'd1,
		OP_TIMES = 2'd2,
		OP_OPEN  = 2'd3
	} op_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_NONE      = 2'd0,
		ERR_VAL_UNDER = 2'd1,
		ERR_OP_UNDER  = 2'd2,
		ERR_OVERFLOW  = 2'd3
	} err_t;

	// Register indexes
	localparam logic REG_TARGET = 1'b0;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TOKEN,
		ST_CLOSE,
		ST_DROP,
		ST_AP_CHK,
		ST_AP_RD,
		ST_EXEC,
		ST_MUL1,
		ST_MUL2,
		ST_MUL_WB,
		ST_FINAL,
		ST_DIST,
		ST_OUT
	} state_t;

	// Where an operation returns to once applied
	typedef enum logic {
		RET_CLOSE,
		RET_FINAL
	} ret_t;

	// Multiplier partial-product steps
	typedef enum logic [1:0] {
		MUL_LL = 2'd0,
		MUL_LH = 2'd1,
		MUL_HL = 2'd2
	} mul_t;

	typedef struct packed {
		logic cap_token;
		logic push_val;
		logic push_op;
		logic raise;
		err_t raise_code;
		logic apply_rd;
		logic apply_pop;
		logic exec_add;
		logic mul_en;
		mul_t mul_sel;
		logic mul_wb;
		logic drop_open;
		logic drop_load;
		logic dist_calc;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic [OPC_W-1:0] opcode;
		logic             last;
		cnt_t             vcount;
		cnt_t             ocount;
		op_t              op_top;
		op_t              cur_op;
		err_t             err;
		logic             out_free;
	} sts_t;

	function automatic op_t tok_to_op(input logic [OPC_W-1:0] tok);
		op_t r;
		case (tok)
			TOK_PLUS:  r = OP_PLUS;
			TOK_MINUS: r = OP_MINUS;
			TOK_TIMES: r = OP_TIMES;
			default:   r = OP_OPEN;
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/parenthesized_expression_evaluator_unit.sv =====
// Infix expression evaluator with a value stack and an operator stack.
// Input channel (in_valid/in_stall): one token per item - opcode, number_value
// and last_token. An item is taken when in_valid is high and in_stall is low.
// Output channel (out_valid/out_stall): one item per expression, produced only
// for a token marked last: expression_value, target_distance and error_code.
// The target is written through the APB port at byte address 0.
// Sequence: each token is captured, then handled alone; in_stall stays high until
// it is done. A closing parenthesis applies each pending + or - (check, operand
// fetch, add) and each pending * (check, fetch, multiply steps, write-back),
// then drops the opening parenthesis. A last token adds the final operation, then
// the distance calculation and the output load. The operand fetch from the stack
// RAMs and the shared 32x32 multiplier (three partial products) set these steps.
// The output register holds a finished item while out_stall is high; tokens are still
// accepted until the next result, which waits for the register and stalls the input.
// Reset empties both stacks, clears the error status, drops any pending
// output item and sets the target to 0. Stack RAM contents are not cleared.
module parenthesized_expression_evaluator_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	// Register port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [pee_pkg::ADDR_W-1:0]        paddr,
	input  logic [pee_pkg::DATA_W-1:0]        pwdata,
	output logic [pee_pkg::DATA_W-1:0]        prdata,
	output logic                              pready,
	// Token input
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [pee_pkg::OPC_W-1:0]         opcode,
	input  logic [pee_pkg::NUM_W-1:0]         number_value,
	input  logic                              last_token,
	// Result output
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [pee_pkg::VAL_W-1:0]  expression_value,
	output logic [pee_pkg::DIST_W-1:0]        target_distance,
	output logic [pee_pkg::ERR_W-1:0]         error_code
);
	import pee_pkg::*;

	logic signed [TGT_W-1:0] target_q;
	logic                    reg_hit;
	cmd_t                    cmd;
	sts_t                    sts;

	// Target register
	assign reg_hit = (paddr[ADDR_W-1] == REG_TARGET);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (psel && penable && pwrite && reg_hit) begin
			target_q <= pwdata[TGT_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = reg_hit ? DATA_W'(unsigned'(target_q)) : '0;

	pee_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	pee_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.opcode           (opcode),
		.number_value     (number_value),
		.last_token       (last_token),
		.target_value     (target_q),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.expression_value (expression_value),
		.target_distance  (target_distance),
		.error_code       (error_code)
	);

	// One token in flight: an accepted item blocks the next cycle
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("token accepted while previous one in progress");

	// Stack counts never pass the depth
	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		sts.vcount <= cnt_t'(STACK_DEPTH) && sts.ocount <= cnt_t'(STACK_DEPTH))
		else $error("stack count beyond depth");

	// An errored expression reports zero value and distance
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != ERR_NONE |-> expression_value == '0 && target_distance == '0)
		else $error("errored result carries nonzero payload");

endmodule

// ===== hdl/pee_ram.sv =====
module pee_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/pee_ctrl.sv =====
module pee_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  pee_pkg::sts_t sts,
	output pee_pkg::cmd_t cmd
);
	import pee_pkg::*;

	state_t state_q, state_d;
	ret_t   ret_q, ret_d;
	state_t post_st;

	// State and return-point registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= RET_CLOSE;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

	// After a token's own work: finish the expression or wait for the next item
	assign post_st  = sts.last ? ST_FINAL : ST_IDLE;
	assign in_stall = (state_q != ST_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.cap_token = 1'b1;
					state_d       = ST_TOKEN;
				end
			end
			ST_TOKEN: begin
				state_d = post_st;
				if (sts.err == ERR_NONE) begin
					case (sts.opcode)
						TOK_NUM: begin
							if (sts.vcount >= cnt_t'(STACK_DEPTH)) begin
								cmd.raise      = 1'b1;
								cmd.raise_code = ERR_OVERFLOW;
							end else begin
								cmd.push_val = 1'b1;
							end
						end
						TOK_PLUS, TOK_MINUS, TOK_TIMES, TOK_OPEN: begin
							if (sts.ocount >= cnt_t'(STACK_DEPTH)) begin
								cmd.raise      = 1'b1;
								cmd.raise_code = ERR_OVERFLOW;
							end else begin
								cmd.push_op = 1'b1;
							end
						end
						TOK_CLOSE: begin
							ret_d   = RET_CLOSE;
							state_d = ST_CLOSE;
						end
						default: ;
					endcase
				end
			end
			ST_CLOSE: begin
				if (sts.ocount == '0) begin
					cmd.raise      = 1'b1;
					cmd.raise_code = ERR_OP_UNDER;
					state_d        = post_st;
				end else if (sts.op_top == OP_OPEN) begin
					cmd.drop_open = 1'b1;
					state_d       = ST_DROP;
				end else begin
					state_d = ST_AP_CHK;
				end
			end
			ST_DROP: begin
				cmd.drop_load = 1'b1;
				state_d       = post_st;
			end
			// Operand checks, then fetch the value and operator below the tops
			ST_AP_CHK: begin
				if (sts.vcount < cnt_t'(2)) begin
					cmd.raise      = 1'b1;
					cmd.raise_code = ERR_VAL_UNDER;
					state_d        = (ret_q == RET_FINAL) ? ST_DIST : post_st;
				end else if (sts.ocount == '0 || sts.op_top == OP_OPEN) begin
					cmd.raise      = 1'b1;
					cmd.raise_code = ERR_OP_UNDER;
					state_d        = (ret_q == RET_FINAL) ? ST_DIST : post_st;
				end else begin
					cmd.apply_rd = 1'b1;
					state_d      = ST_AP_RD;
				end
			end
			ST_AP_RD: begin
				cmd.apply_pop = 1'b1;
				state_d       = ST_EXEC;
			end
			ST_EXEC: begin
				if (sts.cur_op == OP_TIMES) begin
					cmd.mul_en  = 1'b1;
					cmd.mul_sel = MUL_LL;
					state_d     = ST_MUL1;
				end else begin
					cmd.exec_add = 1'b1;
					state_d      = (ret_q == RET_FINAL) ? ST_DIST : ST_CLOSE;
				end
			end
			ST_MUL1: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_LH;
				state_d     = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_HL;
				state_d     = ST_MUL_WB;
			end
			ST_MUL_WB: begin
				cmd.mul_wb = 1'b1;
				state_d    = (ret_q == RET_FINAL) ? ST_DIST : ST_CLOSE;
			end
			// Last token: one more operation unless an error is already kept
			ST_FINAL: begin
				ret_d = RET_FINAL;
				if (sts.err != ERR_NONE) begin
					state_d = ST_DIST;
				end else begin
					state_d = ST_AP_CHK;
				end
			end
			ST_DIST: begin
				cmd.dist_calc = 1'b1;
				state_d       = ST_OUT;
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== hdl/pee_dp.sv =====
module pee_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  pee_pkg::cmd_t                    cmd,
	output pee_pkg::sts_t                    sts,
	input  logic [pee_pkg::OPC_W-1:0]        opcode,
	input  logic [pee_pkg::NUM_W-1:0]        number_value,
	input  logic                             last_token,
	input  logic signed [pee_pkg::TGT_W-1:0] target_value,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [pee_pkg::VAL_W-1:0] expression_value,
	output logic [pee_pkg::DIST_W-1:0]       target_distance,
	output logic [pee_pkg::ERR_W-1:0]        error_code
);
	import pee_pkg::*;

	// Token registers
	logic [OPC_W-1:0] opcode_q;
	logic [NUM_W-1:0] num_q;
	logic             last_q;

	// Stack control and tops
	cnt_t             vcount_q, ocount_q;
	err_t             err_q;
	logic [VAL_W-1:0] tos_q, lhs_q, acc_q;
	op_t              op_top_q, cur_op_q;
	logic [VAL_W:0]   diff_q;

	// Output registers
	logic                    out_valid_q;
	logic [VAL_W-1:0]        out_val_q;
	logic [DIST_W-1:0]       out_dist_q;
	err_t                    out_err_q;

	cnt_t             vc_m1, vc_m2, oc_m1, oc_m2;
	logic [VAL_W-1:0] vram_rdata;
	logic [OPR_W-1:0] oram_rdata;
	logic             oram_re;

	logic [HALF_W-1:0]   mul_a, mul_b;
	logic [VAL_W-1:0]    prod;
	logic [VAL_W:0]      mag;
	logic [DIST_W-1:0]   dist_sat;

	assign vc_m1 = vcount_q - cnt_t'(1);
	assign vc_m2 = vcount_q - cnt_t'(2);
	assign oc_m1 = ocount_q - cnt_t'(1);
	assign oc_m2 = ocount_q - cnt_t'(2);

	// Entries below the top of each stack live in RAM; the tops are registers
	pee_ram #(.WIDTH(VAL_W), .DEPTH(STACK_DEPTH)) u_vram (
		.clk   (clk),
		.we    (cmd.push_val && vcount_q != '0),
		.waddr (vc_m1[IDX_W-1:0]),
		.wdata (tos_q),
		.re    (cmd.apply_rd),
		.raddr (vc_m2[IDX_W-1:0]),
		.rdata (vram_rdata)
	);

	assign oram_re = cmd.apply_rd || cmd.drop_open;

	pee_ram #(.WIDTH(OPR_W), .DEPTH(STACK_DEPTH)) u_oram (
		.clk   (clk),
		.we    (cmd.push_op && ocount_q != '0),
		.waddr (oc_m1[IDX_W-1:0]),
		.wdata (op_top_q),
		.re    (oram_re),
		.raddr (oc_m2[IDX_W-1:0]),
		.rdata (oram_rdata)
	);

	// Shared 32x32 multiplier, one partial product per step
	always_comb begin
		case (cmd.mul_sel)
			MUL_LH: begin
				mul_a = lhs_q[HALF_W-1:0];
				mul_b = tos_q[VAL_W-1:HALF_W];
			end
			MUL_HL: begin
				mul_a = lhs_q[VAL_W-1:HALF_W];
				mul_b = tos_q[HALF_W-1:0];
			end
			default: begin
				mul_a = lhs_q[HALF_W-1:0];
				mul_b = tos_q[HALF_W-1:0];
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	// Absolute distance, saturated
	assign mag      = diff_q[VAL_W] ? (~diff_q + 1'b1) : diff_q;
	assign dist_sat = (mag[VAL_W:DIST_W] != '0) ? {DIST_W{1'b1}} : mag[DIST_W-1:0];

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q    <= '0;
			ocount_q    <= '0;
			err_q       <= ERR_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.push_val) begin
				vcount_q <= vcount_q + cnt_t'(1);
			end
			if (cmd.push_op) begin
				ocount_q <= ocount_q + cnt_t'(1);
			end
			if (cmd.apply_pop) begin
				vcount_q <= vc_m1;
				ocount_q <= oc_m1;
			end
			if (cmd.drop_open) begin
				ocount_q <= oc_m1;
			end
			if (cmd.raise && err_q == ERR_NONE) begin
				err_q <= cmd.raise_code;
			end
			if (cmd.out_load) begin
				vcount_q    <= '0;
				ocount_q    <= '0;
				err_q       <= ERR_NONE;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.cap_token) begin
			opcode_q <= opcode;
			num_q    <= number_value;
			last_q   <= last_token;
		end
		if (cmd.push_val) begin
			tos_q <= {{(VAL_W-NUM_W){1'b0}}, num_q};
		end
		if (cmd.push_op) begin
			op_top_q <= tok_to_op(opcode_q);
		end
		if (cmd.apply_pop) begin
			lhs_q    <= vram_rdata;
			cur_op_q <= op_top_q;
			op_top_q <= op_t'(oram_rdata);
		end
		if (cmd.drop_load) begin
			op_top_q <= op_t'(oram_rdata);
		end
		if (cmd.exec_add) begin
			tos_q <= (cur_op_q == OP_MINUS) ? (lhs_q - tos_q) : (lhs_q + tos_q);
		end
		if (cmd.mul_en) begin
			if (cmd.mul_sel == MUL_LL) begin
				acc_q <= prod;
			end else begin
				acc_q[VAL_W-1:HALF_W] <= acc_q[VAL_W-1:HALF_W] + prod[HALF_W-1:0];
			end
		end
		if (cmd.mul_wb) begin
			tos_q <= acc_q;
		end
		if (cmd.dist_calc) begin
			diff_q <= {tos_q[VAL_W-1], tos_q}
				- {{(VAL_W+1-TGT_W){target_value[TGT_W-1]}}, target_value};
		end
		if (cmd.out_load) begin
			out_err_q <= err_q;
			if (err_q == ERR_NONE) begin
				out_val_q  <= tos_q;
				out_dist_q <= dist_sat;
			end else begin
				out_val_q  <= '0;
				out_dist_q <= '0;
			end
		end
	end

	// Status to the controller
	assign sts.opcode   = opcode_q;
	assign sts.last     = last_q;
	assign sts.vcount   = vcount_q;
	assign sts.ocount   = ocount_q;
	assign sts.op_top   = op_top_q;
	assign sts.cur_op   = cur_op_q;
	assign sts.err      = err_q;
	assign sts.out_free = !out_valid_q || !out_stall;

	assign out_valid        = out_valid_q;
	assign expression_value = out_val_q;
	assign target_distance  = out_dist_q;
	assign error_code       = out_err_q;

endmodule

// ===== dv/expr_value_monitor.sv =====
module expr_value_monitor
	import pee_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	// register port
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [ADDR_W-1:0]        paddr,
	input  logic [DATA_W-1:0]        pwdata,
	input  logic [DATA_W-1:0]        prdata,
	input  logic                     pready,
	// token channel
	input  logic                     in_valid,
	input  logic                     in_stall,
	input  logic [OPC_W-1:0]         opcode,
	input  logic [NUM_W-1:0]         number_value,
	input  logic                     last_token,
	// result channel
	input  logic                     out_valid,
	input  logic                     out_stall,
	input  logic signed [VAL_W-1:0]  expression_value,
	input  logic [DIST_W-1:0]        target_distance,
	input  logic [ERR_W-1:0]         error_code,
	output int                       fail_count,
	output int                       outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [ADDR_W-1:0] TARGET_ADDR = ADDR_W'(4 * int'(REG_TARGET));

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic [DIST_W-1:0]       distance;
		err_t                    code;
	} outcome_t;

	// shadow of the evaluator state
	logic signed [VAL_W-1:0] val_stack [STACK_DEPTH];
	op_t                     opr_stack [STACK_DEPTH];
	int                      val_depth;
	int                      opr_depth;
	err_t                    err_held;
	logic [TGT_W-1:0]        target_reg;
	outcome_t                due_results [$];

	// only the first error of an expression sticks
	function automatic void note_error(err_t code);
		if (err_held == ERR_NONE) err_held = code;
	endfunction

	function automatic void push_value(logic signed [VAL_W-1:0] v);
		if (val_depth >= STACK_DEPTH) begin
			note_error(ERR_OVERFLOW);
		end else begin
			val_stack[val_depth] = v;
			val_depth++;
		end
	endfunction

	function automatic void push_operator(op_t o);
		if (opr_depth >= STACK_DEPTH) begin
			note_error(ERR_OVERFLOW);
		end else begin
			opr_stack[opr_depth] = o;
			opr_depth++;
		end
	endfunction

	// combine the two top values with the top operator; values checked first
	function automatic err_t apply_top();
		logic signed [VAL_W-1:0] lhs, rhs, r;
		op_t                     o;
		if (val_depth < 2) return ERR_VAL_UNDER;
		if (opr_depth == 0 || opr_stack[opr_depth-1] == OP_OPEN) return ERR_OP_UNDER;
		rhs = val_stack[val_depth-1];
		lhs = val_stack[val_depth-2];
		o = opr_stack[opr_depth-1];
		val_depth -= 2;
		opr_depth--;
		case (o)
			OP_PLUS:  r = lhs + rhs;
			OP_MINUS: r = lhs - rhs;
			default:  r = lhs * rhs;
		endcase
		val_stack[val_depth] = r;
		val_depth++;
		return ERR_NONE;
	endfunction

	// closing parenthesis: unwind to the matching open, then drop it
	function automatic void close_group();
		err_t e;
		while (opr_depth > 0 && opr_stack[opr_depth-1] != OP_OPEN) begin
			e = apply_top();
			if (e != ERR_NONE) begin
				note_error(e);
				return;
			end
		end
		if (opr_depth == 0) note_error(ERR_OP_UNDER);
		else opr_depth--;
	endfunction

	function automatic void predict_token(logic [OPC_W-1:0] kind, logic [NUM_W-1:0] num,
			logic fin);
		outcome_t         o;
		logic [VAL_W:0]   gap;
		if (err_held == ERR_NONE) begin
			case (kind)
				TOK_NUM:   push_value({{(VAL_W-NUM_W){1'b0}}, num});
				TOK_PLUS:  push_operator(OP_PLUS);
				TOK_MINUS: push_operator(OP_MINUS);
				TOK_TIMES: push_operator(OP_TIMES);
				TOK_OPEN:  push_operator(OP_OPEN);
				TOK_CLOSE: close_group();
				default: ;
			endcase
		end
		if (!fin) return;
		if (err_held == ERR_NONE) note_error(apply_top());
		o = '0;
		o.code = err_held;
		if (err_held == ERR_NONE) begin
			o.value = val_stack[val_depth-1];
			// 65-bit difference so the magnitude never wraps
			gap = {o.value[VAL_W-1], o.value}
				- {{(VAL_W+1-TGT_W){target_reg[TGT_W-1]}}, target_reg};
			if (gap[VAL_W]) gap = -gap;
			o.distance = gap[VAL_W-1] ? '1 : gap[DIST_W-1:0];
		end
		due_results.insert(due_results.size(), o);
		val_depth = 0;
		opr_depth = 0;
		err_held = ERR_NONE;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			val_depth = 0;
			opr_depth = 0;
			err_held = ERR_NONE;
			target_reg = '0;
			due_results.delete();
			fail_count = 0;
			outstanding <= 0;
		end else begin
			// result side
			if (out_valid && !out_stall) begin
				if (due_results.size() == 0) begin
					$error("result item with none pending: expression_value %0d, error_code %0d",
						expression_value, error_code);
					fail_count++;
				end else begin
					want = due_results.pop_front();
					if (expression_value !== want.value) begin
						$error("expression_value: expected %0d, got %0d",
							want.value, expression_value);
						fail_count++;
					end
					if (target_distance !== want.distance) begin
						$error("target_distance: expected %0d, got %0d",
							want.distance, target_distance);
						fail_count++;
					end
					if (error_code !== want.code) begin
						$error("error_code: expected %0d, got %0d", want.code, error_code);
						fail_count++;
					end
				end
			end
			// token side
			if (in_valid && !in_stall) predict_token(opcode, number_value, last_token);
			// register port: track writes, check reads
			if (psel && penable && pready && paddr == TARGET_ADDR) begin
				if (pwrite) begin
					target_reg = pwdata[TGT_W-1:0];
				end else if (prdata !== DATA_W'(target_reg)) begin
					$error("prdata: expected %0d, got %0d", target_reg, prdata);
					fail_count++;
				end
			end
			outstanding <= due_results.size();
		end
	end

endmodule

// ===== dv/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import pee_pkg::*;

	localparam int GAP_MAX      = 13;
	localparam int DRAIN_CYCLES = 250;
	localparam int STALL_LIMIT  = 4000;
	localparam int TOKEN_GOAL   = 450;
	localparam int PHASES       = 6;
	localparam logic [OPC_W-1:0]  TOK_UNKNOWN = 3'd7;
	localparam logic [ADDR_W-1:0] TARGET_ADDR = ADDR_W'(4 * int'(REG_TARGET));

	logic                    clk;
	logic                    arst_n       = 1'b0;
	logic                    psel         = 1'b0;
	logic                    penable      = 1'b0;
	logic                    pwrite       = 1'b0;
	logic [ADDR_W-1:0]       paddr        = '0;
	logic [DATA_W-1:0]       pwdata       = '0;
	logic [DATA_W-1:0]       prdata;
	logic                    pready;
	logic                    in_valid     = 1'b0;
	logic                    in_stall;
	logic [OPC_W-1:0]        opcode       = '0;
	logic [NUM_W-1:0]        number_value = '0;
	logic                    last_token   = 1'b0;
	logic                    out_valid;
	logic                    out_stall    = 1'b0;
	logic signed [VAL_W-1:0] expression_value;
	logic [DIST_W-1:0]       target_distance;
	logic [ERR_W-1:0]        error_code;

	int fail_count;
	int outstanding;
	int tokens_sent;
	int exprs_sent;
	int idle_cycles;
	bit tx_calm;
	bit rx_calm;

	typedef struct {
		logic [OPC_W-1:0] kind;
		logic [NUM_W-1:0] num;
	} token_t;

	token_t expr_q [$];

	parenthesized_expression_evaluator_unit dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
		.number_value(number_value), .last_token(last_token),
		.out_valid(out_valid), .out_stall(out_stall),
		.expression_value(expression_value), .target_distance(target_distance),
		.error_code(error_code)
	);

	expr_value_monitor mon (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
		.number_value(number_value), .last_token(last_token),
		.out_valid(out_valid), .out_stall(out_stall),
		.expression_value(expression_value), .target_distance(target_distance),
		.error_code(error_code),
		.fail_count(fail_count), .outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// watchdog: too long without any handshake ends the run
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// result receiver: random stall per item, with calm stretches
	initial begin
		int hold;
		forever begin
			if ($urandom_range(5, 0) == 0) rx_calm = !rx_calm;
			hold = rx_calm ? 0 : $urandom_range(GAP_MAX, 0);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic reg_access(logic wr, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic send_token(logic [OPC_W-1:0] kind, logic [NUM_W-1:0] num, logic fin);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(GAP_MAX, 0);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= kind;
		number_value <= num;
		last_token <= fin;
		do @(posedge clk); while (in_stall);
		if (kind != TOK_SKIP && kind != TOK_UNKNOWN) tokens_sent++;
		if (fin) exprs_sent++;
	endtask

	// send the queued expression, marking its final token as last
	task automatic send_expr();
		foreach (expr_q[i]) send_token(expr_q[i].kind, expr_q[i].num, i == expr_q.size() - 1);
		expr_q.delete();
	endtask

	// wait until every result is back and the block has gone quiet
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic void queue_token(logic [OPC_W-1:0] kind, logic [NUM_W-1:0] num);
		token_t t;
		t.kind = kind;
		t.num = num;
		expr_q.insert(expr_q.size(), t);
	endfunction

	function automatic logic [NUM_W-1:0] pick_number();
		case ($urandom_range(9, 0))
			0, 1, 2, 3: return $urandom_range(15, 0);
			4, 5, 6:    return $urandom;
			7:          return '1;
			8:          return 32'h8000_0000;
			default:    return $urandom_range(1000, 0);
		endcase
	endfunction

	function automatic logic [OPC_W-1:0] pick_operator();
		case ($urandom_range(2, 0))
			0:       return TOK_PLUS;
			1:       return TOK_MINUS;
			default: return TOK_TIMES;
		endcase
	endfunction

	// a number, or a parenthesized chain of one to three operators
	function automatic void grow_term(int depth);
		int links;
		if ($urandom_range(9, 0) == 0) queue_token($urandom_range(1, 0) ? TOK_SKIP : TOK_UNKNOWN,
			$urandom);
		if (depth == 0 || $urandom_range(2, 0) == 0) begin
			queue_token(TOK_NUM, pick_number());
		end else begin
			links = $urandom_range(3, 1);
			queue_token(TOK_OPEN, $urandom);
			grow_term(depth - 1);
			repeat (links) begin
				queue_token(pick_operator(), $urandom);
				grow_term(depth - 1);
			end
			queue_token(TOK_CLOSE, $urandom);
		end
	endfunction

	// top level is exactly one binary operation, which the last token applies
	function automatic void build_wellformed();
		grow_term($urandom_range(7, 0) == 0 ? 3 : $urandom_range(2, 0));
		queue_token(pick_operator(), $urandom);
		grow_term($urandom_range(7, 0) == 0 ? 3 : $urandom_range(2, 0));
	endfunction

	function automatic void build_noise();
		int n;
		logic [OPC_W-1:0] kind;
		case ($urandom_range(2, 0))
			0: begin
				// random token soup
				n = $urandom_range(10, 1);
				repeat (n) queue_token(OPC_W'($urandom_range(7, 0)), $urandom);
			end
			1: begin
				// flood one stack up to or past its depth
				n = $urandom_range(STACK_DEPTH + 4, STACK_DEPTH - 2);
				kind = $urandom_range(1, 0) ? TOK_NUM : TOK_OPEN;
				repeat (n) queue_token(kind, pick_number());
				if ($urandom_range(1, 0)) queue_token(pick_operator(), $urandom);
			end
			default: begin
				// well-formed expression cut short
				build_wellformed();
				n = $urandom_range(expr_q.size() - 1, 1);
				while (expr_q.size() > n) void'(expr_q.pop_back());
			end
		endcase
	endfunction

	initial begin
		logic [TGT_W-1:0] settings [PHASES];
		settings[0] = 32'd1;
		settings[1] = 32'h7FFF_FFFF;
		settings[2] = 32'h8000_0000;
		settings[3] = 32'hFFFF_FFFF;
		settings[4] = $urandom;
		settings[5] = 32'd0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		reg_access(1'b0, TARGET_ADDR, '0);

		// directed: widest number plus zero
		queue_token(TOK_NUM, 32'hFFFF_FFFF);
		queue_token(TOK_PLUS, '0);
		queue_token(TOK_NUM, '0);
		send_expr();
		// (2^31 * 2^31) * 2 wraps to the most negative value; distance saturates
		queue_token(TOK_OPEN, '0);
		queue_token(TOK_NUM, 32'h8000_0000);
		queue_token(TOK_TIMES, '0);
		queue_token(TOK_NUM, 32'h8000_0000);
		queue_token(TOK_CLOSE, '0);
		queue_token(TOK_TIMES, '0);
		queue_token(TOK_NUM, 32'd2);
		send_expr();
		// final operation short of a value
		queue_token(TOK_NUM, 32'd5);
		queue_token(TOK_PLUS, '0);
		send_expr();
		// final operation with no operator
		queue_token(TOK_NUM, 32'd1);
		queue_token(TOK_NUM, 32'd2);
		send_expr();
		// close without open; later tokens are dropped
		queue_token(TOK_NUM, 32'd3);
		queue_token(TOK_CLOSE, '0);
		queue_token(TOK_PLUS, '0);
		queue_token(TOK_NUM, 32'd4);
		send_expr();
		// open parenthesis where the final operator should be
		queue_token(TOK_OPEN, '0);
		queue_token(TOK_NUM, 32'd1);
		queue_token(TOK_NUM, 32'd2);
		send_expr();
		// ignored and unknown kinds around a subtraction going negative
		queue_token(TOK_SKIP, '1);
		queue_token(TOK_NUM, 32'd9);
		queue_token(TOK_UNKNOWN, '1);
		queue_token(TOK_MINUS, '0);
		queue_token(TOK_SKIP, '0);
		queue_token(TOK_NUM, 32'd11);
		send_expr();

		// random phases, one target setting each
		for (int p = 0; p < PHASES; p++) begin
			drain();
			reg_access(1'b1, TARGET_ADDR, DATA_W'(settings[p]));
			reg_access(1'b0, TARGET_ADDR, '0);
			while (tokens_sent < (p + 1) * TOKEN_GOAL / PHASES) begin
				tx_calm = ($urandom_range(3, 0) == 0);
				if ($urandom_range(3, 0) == 0) build_noise();
				else build_wellformed();
				send_expr();
				// occasionally hold off until the pipe is empty
				if ($urandom_range(15, 0) == 0) begin
					in_valid <= 1'b0;
					do @(posedge clk); while (outstanding != 0);
				end
			end
		end
		in_valid <= 1'b0;
		drain();

		$display("covered %0d tokens in %0d expressions over %0d target settings,",
			tokens_sent, exprs_sent, PHASES + 1);
		$display("with stack floods, underflows, stray parentheses and ignored kinds mixed in");
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
